[design/ctp_pkg.sv]
// ---------------------------------------------------------------------------
// ctp_pkg
// Shared types, character codes and saturating arithmetic for the clock-time
// text parser.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package ctp_pkg;

  localparam int SECONDS_WIDTH = 40;

  localparam logic [SECONDS_WIDTH-1:0] SECONDS_MAX = {SECONDS_WIDTH{1'b1}};
  localparam logic [SECONDS_WIDTH-1:0] PART_MAX    = SECONDS_WIDTH'(59);

  localparam logic [1:0] INDEX_LAST   = 2'd2;  // hh:mm:ss has three parts
  localparam logic [1:0] DIGITS_MAX   = 2'd2;  // later parts: two digits
  localparam logic [1:0] DIGITS_STUCK = 2'd3;  // count sticks here

  // Character codes
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_COLON = 8'h3A;

  typedef enum logic [1:0] {
    PH_LEAD   = 2'd0,  // leading blanks of a part
    PH_DIGITS = 2'd1,
    PH_TRAIL  = 2'd2   // blanks after the digits of a part
  } ctp_phase_t;

  typedef struct packed {
    logic [7:0] character;
    logic       last;
  } ctp_in_t;

  typedef struct packed {
    logic                     valid_res;
    logic [SECONDS_WIDTH-1:0] total_seconds;
    logic                     saturated;
  } ctp_out_t;

  typedef struct packed {
    ctp_phase_t               field_phase;
    logic [1:0]               field_index;
    logic [SECONDS_WIDTH-1:0] field_value;
    logic [1:0]               field_digit_count;
    logic [SECONDS_WIDTH-1:0] running_total;
    logic                     seen_content;
    logic                     pending_line_break;
    logic                     failed;
    logic                     clipped;
  } ctp_state_t;

  localparam ctp_state_t STATE_CLEAR = '{
    field_phase:        PH_LEAD,
    field_index:        2'd0,
    field_value:        '0,
    field_digit_count:  2'd0,
    running_total:      '0,
    seen_content:       1'b0,
    pending_line_break: 1'b0,
    failed:             1'b0,
    clipped:            1'b0
  };

  typedef struct packed {
    logic [SECONDS_WIDTH-1:0] value;
    logic                     clip;
  } ctp_sat_t;

  function automatic ctp_sat_t sat_add(input logic [SECONDS_WIDTH-1:0] a,
                                       input logic [SECONDS_WIDTH-1:0] b);
    logic [SECONDS_WIDTH:0] s;
    ctp_sat_t               r;
    s       = {1'b0, a} + {1'b0, b};
    r.clip  = (a == SECONDS_MAX) || s[SECONDS_WIDTH];
    r.value = r.clip ? SECONDS_MAX : s[SECONDS_WIDTH-1:0];
    return r;
  endfunction

  // a * 10 as (a << 3) + (a << 1)
  function automatic ctp_sat_t sat_mul10(input logic [SECONDS_WIDTH-1:0] a);
    logic [SECONDS_WIDTH+3:0] p;
    ctp_sat_t                 r;
    p       = ({4'b0, a} << 3) + ({4'b0, a} << 1);
    r.clip  = (a == SECONDS_MAX) || (|p[SECONDS_WIDTH+3:SECONDS_WIDTH]);
    r.value = r.clip ? SECONDS_MAX : p[SECONDS_WIDTH-1:0];
    return r;
  endfunction

  // a * 60 as (a << 6) - (a << 2)
  function automatic ctp_sat_t sat_mul60(input logic [SECONDS_WIDTH-1:0] a);
    logic [SECONDS_WIDTH+5:0] p;
    ctp_sat_t                 r;
    p       = ({6'b0, a} << 6) - ({6'b0, a} << 2);
    r.clip  = (a == SECONDS_MAX) || (|p[SECONDS_WIDTH+5:SECONDS_WIDTH]);
    r.value = r.clip ? SECONDS_MAX : p[SECONDS_WIDTH-1:0];
    return r;
  endfunction

  // Parts after the first: at most two digits, value at most 59
  function automatic logic part_bad(input logic [1:0]               index,
                                    input logic [1:0]               digits,
                                    input logic [SECONDS_WIDTH-1:0] value);
    return (index != 2'd0) && ((digits > DIGITS_MAX) || (value > PART_MAX));
  endfunction

endpackage

`default_nettype wire

[design/ctp_step.sv]
// ---------------------------------------------------------------------------
// ctp_step
// Next-state logic: folds one character into the parser state.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctp_step (
  input  ctp_pkg::ctp_in_t    item,
  input  ctp_pkg::ctp_state_t cur,
  output ctp_pkg::ctp_state_t nxt
);

  logic [ctp_pkg::SECONDS_WIDTH-1:0] digit;
  ctp_pkg::ctp_sat_t                 dig_mul;
  ctp_pkg::ctp_sat_t                 dig_sum;
  ctp_pkg::ctp_sat_t                 part_sum;
  ctp_pkg::ctp_sat_t                 part_mul;

  assign digit    = {{(ctp_pkg::SECONDS_WIDTH-4){1'b0}}, item.character[3:0]};
  assign dig_mul  = ctp_pkg::sat_mul10(cur.field_value);
  assign dig_sum  = ctp_pkg::sat_add(dig_mul.value, digit);
  assign part_sum = ctp_pkg::sat_add(cur.running_total, cur.field_value);
  assign part_mul = ctp_pkg::sat_mul60(part_sum.value);

  always_comb begin
    nxt = cur;
    if (item.character inside {ctp_pkg::CH_SPACE, ctp_pkg::CH_TAB}) begin
      if (cur.field_phase == ctp_pkg::PH_DIGITS) begin
        nxt.field_phase = ctp_pkg::PH_TRAIL;
      end
    end else if (item.character inside {ctp_pkg::CH_CR, ctp_pkg::CH_LF}) begin
      if (cur.seen_content) begin
        nxt.pending_line_break = 1'b1;
      end
    end else begin
      nxt.seen_content = 1'b1;
      if (cur.pending_line_break) begin
        nxt.failed = 1'b1;
      end else if (item.character inside {[ctp_pkg::CH_ZERO:ctp_pkg::CH_NINE]}) begin
        if (cur.field_phase == ctp_pkg::PH_TRAIL) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.field_phase = ctp_pkg::PH_DIGITS;
          if (cur.field_digit_count != ctp_pkg::DIGITS_STUCK) begin
            nxt.field_digit_count = cur.field_digit_count + 2'd1;
          end
          nxt.field_value = dig_sum.value;
          nxt.clipped     = cur.clipped | dig_mul.clip | dig_sum.clip;
        end
      end else if (item.character == ctp_pkg::CH_COLON) begin
        if (ctp_pkg::part_bad(cur.field_index, cur.field_digit_count,
                              cur.field_value)) begin
          nxt.failed = 1'b1;
        end
        if (cur.field_index >= ctp_pkg::INDEX_LAST) begin
          nxt.failed = 1'b1;
        end else begin
          nxt.running_total = part_mul.value;
          nxt.clipped       = cur.clipped | part_sum.clip | part_mul.clip;
          nxt.field_index   = cur.field_index + 2'd1;
        end
        nxt.field_phase       = ctp_pkg::PH_LEAD;
        nxt.field_value       = '0;
        nxt.field_digit_count = 2'd0;
      end else begin
        nxt.failed = 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

[design/ctp_result.sv]
// ---------------------------------------------------------------------------
// ctp_result
// Closes the string: checks the last part and adds it to the total.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module ctp_result (
  input  ctp_pkg::ctp_state_t st,
  output ctp_pkg::ctp_out_t   res
);

  ctp_pkg::ctp_sat_t sum;
  logic              ok;

  assign sum = ctp_pkg::sat_add(st.running_total, st.field_value);
  assign ok  = st.seen_content && !st.failed &&
               !ctp_pkg::part_bad(st.field_index, st.field_digit_count, st.field_value);

  assign res.valid_res     = ok;
  assign res.total_seconds = ok ? sum.value : '0;
  assign res.saturated     = ok && (st.clipped || sum.clip);

endmodule

`default_nettype wire

[design/clock_time_text_parser.sv]
// ---------------------------------------------------------------------------
// clock_time_text_parser
// Parses "ss", "mm:ss" or "hh:mm:ss" text, one character per item, into a
// saturating count of seconds.
// ---------------------------------------------------------------------------
// Takes one character per cycle while the input side does not stall, and
// gives one result item per string, on the item flagged last. Each character
// lands in an input register; the step logic then folds it into the parser
// state (a multiply-by-ten-and-add for a digit, add-then-multiply-by-sixty
// for a colon), and for the last character the result logic closes the
// string and loads the output register, which drives out_valid. The state
// clears itself after every string, so strings may follow one another
// without a gap. The input side stalls only when a finished result sits
// unclaimed in the output register and the next string's last character is
// waiting behind it.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module clock_time_text_parser (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  input  ctp_pkg::ctp_in_t  in_data,
  output logic              out_valid,
  input  logic              out_ready,
  output ctp_pkg::ctp_out_t out_data
);

  // Input stage
  ctp_pkg::ctp_in_t    in_r;
  logic                in_vld_r;

  // Parser state and its next value
  ctp_pkg::ctp_state_t state_r;
  ctp_pkg::ctp_state_t state_nxt;

  // Result stage
  ctp_pkg::ctp_out_t   res_nxt;
  ctp_pkg::ctp_out_t   out_r;
  logic                out_vld_r;

  logic                consume;

  ctp_step u_step (
    .item (in_r),
    .cur  (state_r),
    .nxt  (state_nxt)
  );

  ctp_result u_result (
    .st  (state_nxt),
    .res (res_nxt)
  );

  // A held character is used up unless it closes a string and the output
  // register still holds a result nobody took.
  assign consume  = in_vld_r && (!in_r.last || !out_vld_r || out_ready);
  assign in_ready = !in_vld_r || consume;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r  <= 1'b0;
      out_vld_r <= 1'b0;
      state_r   <= ctp_pkg::STATE_CLEAR;
    end else begin
      if (in_ready) begin
        in_vld_r <= in_valid;
      end
      if (consume) begin
        // end of string: start fresh for the next one
        state_r <= in_r.last ? ctp_pkg::STATE_CLEAR : state_nxt;
      end
      if (consume && in_r.last) begin
        out_vld_r <= 1'b1;
      end else if (out_ready) begin
        out_vld_r <= 1'b0;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      in_r <= in_data;
    end
    if (consume && in_r.last) begin
      out_r <= res_nxt;
    end
  end

  assign out_valid = out_vld_r;
  assign out_data  = out_r;

  // A finished string always leaves the parser cleared
  a_clear_after_last : assert property (@(posedge clk) disable iff (!rst_n)
    consume && in_r.last |=> state_r == ctp_pkg::STATE_CLEAR)
    else $error("parser state not cleared after last item");

  // An unclaimed result is never overwritten by the next string
  a_no_overwrite : assert property (@(posedge clk) disable iff (!rst_n)
    in_vld_r && in_r.last && out_vld_r && !out_ready |-> !in_ready && !consume)
    else $error("pending result would be overwritten");

  // Invalid results carry no total and no saturation flag
  a_invalid_zero : assert property (@(posedge clk) disable iff (!rst_n)
    out_vld_r |-> out_r.valid_res ||
                  (out_r.total_seconds == '0 && !out_r.saturated))
    else $error("invalid result with nonzero payload");

  // At most three parts
  a_index_range : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.field_index <= ctp_pkg::INDEX_LAST)
    else $error("part index out of range");

  // A line break is only recorded once content has started
  a_break_after_content : assert property (@(posedge clk) disable iff (!rst_n)
    state_r.pending_line_break |-> state_r.seen_content)
    else $error("line break flagged before any content");

endmodule

`default_nettype wire

[tb/clock_time_text_checker.sv]
// ---------------------------------------------------------------------------
// clock_time_text_checker
// Watches both channels of the clock-time text parser, predicts the duration
// of every string from its characters and compares each result item against
// the oldest prediction.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_time_text_checker (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  input  logic              in_ready,
  input  ctp_pkg::ctp_in_t  in_data,
  input  logic              out_valid,
  input  logic              out_ready,
  input  ctp_pkg::ctp_out_t out_data,
  output int                mismatches,
  output int                durations_waiting,
  output int                durations_checked,
  output int                durations_valid,
  output int                durations_clipped
);

  import ctp_pkg::*;

  localparam int          W           = SECONDS_WIDTH;
  localparam int unsigned DIGIT_BASE  = 10;
  localparam int unsigned PART_FACTOR = 60;

  // Parser state, own copy
  ctp_phase_t   phase;
  logic [1:0]   part_idx;
  logic [1:0]   part_digits;
  logic [W-1:0] part_val;
  logic [W-1:0] carried;
  logic         content_seen;
  logic         break_seen;
  logic         malformed;
  logic         clip_seen;

  ctp_out_t expected_times[$];
  ctp_out_t want;
  int       n_err = 0;
  int       n_chk = 0;
  int       n_val = 0;
  int       n_clip = 0;

  function automatic logic [W-1:0] clamp_add(input logic [W-1:0] a, input logic [W-1:0] b);
    logic [W:0] s;
    s = {1'b0, a} + {1'b0, b};
    if (a == SECONDS_MAX || s > {1'b0, SECONDS_MAX}) begin
      clip_seen = 1'b1;
      return SECONDS_MAX;
    end
    return s[W-1:0];
  endfunction

  function automatic logic [W-1:0] clamp_mul(input logic [W-1:0] a, input int unsigned k);
    logic [W+7:0] p;
    p = (W+8)'(a) * (W+8)'(k);
    if (a == SECONDS_MAX || p > (W+8)'(SECONDS_MAX)) begin
      clip_seen = 1'b1;
      return SECONDS_MAX;
    end
    return p[W-1:0];
  endfunction

  // minutes and seconds parts: two digits at most, 59 at most
  function automatic logic part_out_of_range();
    return (part_idx != 2'd0) && (part_digits > DIGITS_MAX || part_val > PART_MAX);
  endfunction

  task automatic clear_parse();
    phase        = PH_LEAD;
    part_idx     = 2'd0;
    part_digits  = 2'd0;
    part_val     = '0;
    carried      = '0;
    content_seen = 1'b0;
    break_seen   = 1'b0;
    malformed    = 1'b0;
    clip_seen    = 1'b0;
  endtask

  // Fold one character into the state; on the last one queue the duration.
  task automatic parse_char(input ctp_in_t item);
    logic [7:0]   c;
    logic [W-1:0] total;
    logic         ok;
    ctp_out_t     res;
    c = item.character;
    if (c == CH_SPACE || c == CH_TAB) begin
      if (phase == PH_DIGITS) phase = PH_TRAIL;
    end else if (c == CH_CR || c == CH_LF) begin
      if (content_seen) break_seen = 1'b1;
    end else begin
      content_seen = 1'b1;
      if (break_seen) begin
        malformed = 1'b1;
      end else if (c >= CH_ZERO && c <= CH_NINE) begin
        if (phase == PH_TRAIL) begin
          malformed = 1'b1;
        end else begin
          phase = PH_DIGITS;
          if (part_digits < DIGITS_STUCK) part_digits++;
          part_val = clamp_add(clamp_mul(part_val, DIGIT_BASE), W'(c - CH_ZERO));
        end
      end else if (c == CH_COLON) begin
        if (part_out_of_range()) malformed = 1'b1;
        if (part_idx >= INDEX_LAST) begin
          malformed = 1'b1;
        end else begin
          carried = clamp_mul(clamp_add(carried, part_val), PART_FACTOR);
          part_idx++;
        end
        phase       = PH_LEAD;
        part_val    = '0;
        part_digits = 2'd0;
      end else begin
        malformed = 1'b1;
      end
    end

    if (item.last) begin
      if (part_out_of_range()) malformed = 1'b1;
      total             = clamp_add(carried, part_val);
      ok                = content_seen && !malformed;
      res.valid_res     = ok;
      res.total_seconds = ok ? total : '0;
      res.saturated     = ok && clip_seen;
      expected_times.insert(expected_times.size(), res);
      clear_parse();
    end
  endtask

  initial clear_parse();

  always @(posedge clk) begin
    if (!rst_n) begin
      clear_parse();
      expected_times.delete();
    end else begin
      if (in_valid && in_ready) parse_char(in_data);

      if (out_valid && out_ready) begin
        if (expected_times.size() == 0) begin
          $error("result item with no string pending: valid_res %0d total_seconds %0d saturated %0d",
                 out_data.valid_res, out_data.total_seconds, out_data.saturated);
          n_err++;
        end else begin
          want = expected_times.pop_front();
          n_chk++;
          if (want.valid_res) n_val++;
          if (want.saturated) n_clip++;
          if (out_data.valid_res !== want.valid_res) begin
            $error("valid_res: expected %0d, actual %0d", want.valid_res, out_data.valid_res);
            n_err++;
          end
          if (out_data.total_seconds !== want.total_seconds) begin
            $error("total_seconds: expected %0d, actual %0d",
                   want.total_seconds, out_data.total_seconds);
            n_err++;
          end
          if (out_data.saturated !== want.saturated) begin
            $error("saturated: expected %0d, actual %0d", want.saturated, out_data.saturated);
            n_err++;
          end
        end
      end
    end

    mismatches        <= n_err;
    durations_waiting <= expected_times.size();
    durations_checked <= n_chk;
    durations_valid   <= n_val;
    durations_clipped <= n_clip;
  end

endmodule

[tb/clock_time_text_parser_tb.sv]
// ---------------------------------------------------------------------------
// clock_time_text_parser_tb
// Drives time strings into the clock-time text parser one character per
// item, directed cases first and then random well-formed, broken and noisy
// strings, while a checker beside the block predicts every duration.
// ---------------------------------------------------------------------------
`timescale 1ns / 1ps

module clock_time_text_parser_tb;

  import ctp_pkg::*;

  localparam int CLK_HALF_NS   = 2;       // 4 ns period
  localparam int RESET_CYCLES  = 7;
  localparam int TARGET_CHARS  = 1000;    // random stimulus stops past this
  localparam int CYCLE_LIMIT   = 200000;  // far beyond the slowest legal run
  localparam int IDLE_PCT      = 35;      // chance of an idle cycle per side
  // Spare cycles at the end catch anything that should not be there.
  localparam int DRAIN_CYCLES  = 10;
  // Receiver holds off this long once, so the block backs up into its input
  localparam int HOLD_START    = 300;
  localparam int HOLD_CYCLES   = 80;
  // Stretches with no idling at all, one per side
  localparam int RX_CALM_START = 900;
  localparam int RX_CALM_LEN   = 250;
  localparam int TX_CALM_START = 450;
  localparam int TX_CALM_LEN   = 200;

  logic              clk       = 1'b0;
  logic              rst_n     = 1'b0;
  logic              in_valid  = 1'b0;
  logic              in_ready;
  ctp_in_t           in_data   = '0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  ctp_out_t          out_data;

  int                mismatches;
  int                durations_waiting;
  int                durations_checked;
  int                durations_valid;
  int                durations_clipped;

  logic [7:0]        text_q[$];    // the string being built, then sent
  int                chars_sent   = 0;
  int                strings_sent = 0;

  // Directed strings: three parts, leading tab with a trailing CR, all
  // blank, stray byte, blank inside digits, inner line break, too many
  // parts, and a seconds part above 59. \015 is CR.
  string directed_texts[] = '{"1:2:3", "\t5\015", "\n", "x", "1 2", "1\n2",
                              ":::", "0:60"};

  clock_time_text_parser dut (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_data   (in_data),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

  clock_time_text_checker checker_i (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_data           (in_data),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_data          (out_data),
    .mismatches        (mismatches),
    .durations_waiting (durations_waiting),
    .durations_checked (durations_checked),
    .durations_valid   (durations_valid),
    .durations_clipped (durations_clipped)
  );

  initial begin
    forever #(CLK_HALF_NS) clk = ~clk;
  end

  // ---- string building ----------------------------------------------------

  // Append one character to the string under construction
  task automatic add_char(input logic [7:0] ch);
    text_q.insert(text_q.size(), ch);
  endtask

  // Blanks around a part; line breaks only where the whole string is trimmed
  task automatic add_blanks(input int max_n, input bit with_breaks);
    int n;
    n = $urandom_range(0, max_n);
    repeat (n) begin
      case ($urandom_range(0, with_breaks ? 3 : 1))
        0:       add_char(CH_SPACE);
        1:       add_char(CH_TAB);
        2:       add_char(CH_CR);
        default: add_char(CH_LF);
      endcase
    end
  endtask

  task automatic add_digits(input int n);
    repeat (n) add_char(CH_ZERO + 8'($urandom_range(0, 9)));
  endtask

  // Two-digit part with a value in [lo, hi]; small values may lose the
  // leading zero
  task automatic add_part_value(input int lo, input int hi);
    int v;
    v = $urandom_range(lo, hi);
    if (v >= 10 || $urandom_range(0, 1))
      add_char(CH_ZERO + 8'(v / 10));
    add_char(CH_ZERO + 8'(v % 10));
  endtask

  task automatic build_random();
    int roll;
    int parts;
    int k;
    int pos;
    roll = $urandom_range(0, 99);
    if (roll < 85) begin
      // ss, mm:ss or hh:mm:ss with random content
      parts = $urandom_range(1, 3);
      add_blanks(2, 1'b1);
      for (k = 0; k < parts; k++) begin
        if (k != 0) add_char(CH_COLON);
        add_blanks(1, 1'b0);
        if (k == 0) begin
          case ($urandom_range(0, 9))
            0:       add_digits(0);                          // empty part
            1:       add_digits($urandom_range(11, 16));     // long runs, may saturate
            2:       add_digits($urandom_range(7, 9));       // big hours
            default: add_digits($urandom_range(1, 3));
          endcase
        end else begin
          case ($urandom_range(0, 11))
            0:       add_digits(0);
            1:       add_digits(3);                          // too many digits
            2:       add_part_value(60, 99);                 // above 59
            default: add_part_value(0, 59);
          endcase
        end
        add_blanks(1, 1'b0);
      end
      add_blanks(2, 1'b1);
      if (text_q.size() == 0) add_char(CH_ZERO);

      // Some of them get broken in one place
      if (roll >= 65) begin
        pos = $urandom_range(0, text_q.size() - 1);
        case ($urandom_range(0, 2))
          0:       text_q[pos] = 8'($urandom_range(0, 255));
          1:       text_q.insert(pos, $urandom_range(0, 1) ? CH_CR : CH_LF);
          default: text_q.insert(pos, CH_COLON);
        endcase
      end
    end else begin
      // Noise: a short run of digits, colons, blanks and arbitrary bytes
      repeat ($urandom_range(1, 6)) begin
        case ($urandom_range(0, 3))
          0:       add_digits(1);
          1:       add_char(CH_COLON);
          2:       add_blanks(1, 1'b1);
          default: add_char(8'($urandom_range(0, 255)));
        endcase
      end
      if (text_q.size() == 0) add_char(CH_SPACE);
    end
  endtask

  // ---- sending ------------------------------------------------------------

  // One character per item. Before each one the sender may idle for a few
  // cycles, except inside its calm stretch. in_valid only drops on the idle
  // path, so it never sees two assignments in one step.
  task automatic send_char(input logic [7:0] ch, input logic is_last);
    ctp_in_t item;
    while (!(chars_sent >= TX_CALM_START && chars_sent < TX_CALM_START + TX_CALM_LEN)
           && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    item.character = ch;
    item.last      = is_last;
    in_valid <= 1'b1;
    in_data  <= item;
    // in_ready read right at the edge is the value the edge saw
    do @(posedge clk); while (!in_ready);
    chars_sent++;
  endtask

  task automatic send_text();
    int i;
    for (i = 0; i < text_q.size(); i++)
      send_char(text_q[i], i == text_q.size() - 1);
    text_q.delete();
    strings_sent++;
  endtask

  // ---- receiver -----------------------------------------------------------

  initial begin : receiver
    int rx_cycle;
    rx_cycle = 0;
    while (!rst_n) @(posedge clk);
    forever begin
      if (rx_cycle >= HOLD_START && rx_cycle < HOLD_START + HOLD_CYCLES)
        out_ready <= 1'b0;   // long hold-off: output fills, input stalls
      else if (rx_cycle >= RX_CALM_START && rx_cycle < RX_CALM_START + RX_CALM_LEN)
        out_ready <= 1'b1;
      else
        out_ready <= ($urandom_range(0, 99) >= IDLE_PCT);
      @(posedge clk);
      rx_cycle++;
    end
  end

  // ---- watchdog -----------------------------------------------------------

  initial begin : watchdog
    int cycle_count;
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $display("Timeout after %0d cycles", CYCLE_LIMIT);
    $display("Some tests failed");
    $finish;
  end

  // ---- main sequence ------------------------------------------------------

  initial begin : stimulus
    int j;
    repeat (RESET_CYCLES) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Directed part
    foreach (directed_texts[i]) begin
      for (j = 0; j < directed_texts[i].len(); j++)
        add_char(directed_texts[i][j]);
      send_text();
    end
    // Character extremes, each as a string of its own
    add_char(8'h00);
    send_text();
    add_char(8'hFF);
    send_text();

    // Random part
    while (chars_sent < TARGET_CHARS) begin
      build_random();
      send_text();
    end
    in_valid <= 1'b0;

    // Let the checker's counts catch up, then drain what is still expected
    @(posedge clk);
    while (durations_waiting != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    $display("Sent %0d strings in %0d characters; %0d durations checked.",
             strings_sent, chars_sent, durations_checked);
    $display("Of those %0d parsed and %0d clipped at the maximum; %0d mismatches.",
             durations_valid, durations_clipped, mismatches);
    if (mismatches == 0 && durations_waiting == 0)
      $display("All tests passed");
    else
      $display("Some tests failed");
    $finish;
  end

endmodule
